// ===== sv/aesvr_pkg.sv =====
// shared types, command codes, s-box and field arithmetic for the variable-round cipher
package aesvr_pkg;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 128;
   localparam int HALF_W  = 64;
   localparam int COL_W   = 32;
   localparam int LANES   = 4;
   localparam int ROUND_W = 4;

   localparam logic [BYTE_W-1:0] GF_POLY = 8'h1b;

   typedef enum logic {
      CMD_LOAD    = 1'b0,
      CMD_ENCRYPT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROUND
   } fsm_state_type;

   localparam logic [BYTE_W-1:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
      8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
      8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
      8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
      8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
      8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
      8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
      8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
      8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
      8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
      8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
      8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
      8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
      8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
      8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
      8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
      8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [BYTE_W-1:0] sbox(input logic [BYTE_W-1:0] x);
      return SBOX[x];
   endfunction

   function automatic logic [BYTE_W-1:0] xtime(input logic [BYTE_W-1:0] x);
      logic [BYTE_W-1:0] y;
      y = {x[BYTE_W-2:0], 1'b0};
      return x[BYTE_W-1] ? (y ^ GF_POLY) : y;
   endfunction

endpackage

// ===== sv/aesvr_ram.sv =====
// generic single-write, single-read ram with registered read data
module aesvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/aesvr_lane.sv =====
// one column lane: s-box on four shifted bytes, optional mix column, round key add
module aesvr_lane (
   input  logic [aesvr_pkg::COL_W-1:0] col_in,
   input  logic [aesvr_pkg::COL_W-1:0] key_col,
   input  logic                        mix_en,
   output logic [aesvr_pkg::COL_W-1:0] col_out
);
   import aesvr_pkg::*;

   logic [BYTE_W-1:0] s0, s1, s2, s3;
   logic [BYTE_W-1:0] m0, m1, m2, m3;
   logic [COL_W-1:0]  pre_key;

   always_comb begin
      s0 = sbox(col_in[31:24]);
      s1 = sbox(col_in[23:16]);
      s2 = sbox(col_in[15:8]);
      s3 = sbox(col_in[7:0]);
      m0 = xtime(s0) ^ xtime(s1) ^ s1 ^ s2 ^ s3;
      m1 = s0 ^ xtime(s1) ^ xtime(s2) ^ s2 ^ s3;
      m2 = s0 ^ s1 ^ xtime(s2) ^ xtime(s3) ^ s3;
      m3 = xtime(s0) ^ s0 ^ s1 ^ s2 ^ xtime(s3);
      pre_key = mix_en ? {m0, m1, m2, m3} : {s0, s1, s2, s3};
      col_out = pre_key ^ key_col;
   end

endmodule

// ===== sv/aes_block_encrypt_variable_rounds_top.sv =====
// top level: key store, round sequencer, four column lanes and merge into the state register
//
// Request channel (req_*): one word per command. A load word (command 0) writes
// data_hi/data_lo into round key slot key_index; slots above MAX_ROUNDS are ignored
// and a load gives no response. An encrypt word (command 1) encrypts data_hi/data_lo
// with keys 0..R, where R is the round count clamped to 1..MAX_ROUNDS.
// Response channel (rsp_*): one ciphertext word per encrypt.
// Config: csr_wr_en/csr_wr_data set the round count (reset value 10); write it only
// while the block is idle.
// Timing: a load leaves the block idle. An encrypt holds the round unit for the
// initial key add and then for each round, each round reading its key from the key
// store in the cycle before; requests stall until the block is idle again.
// The response is valid in the cycle after the last round.
// The response sits in an output register, so the next request is taken while it
// waits. If rsp_stall is still high when the next encrypt reaches its last round,
// that round holds until the pending response is taken.
// Reset is synchronous: it clears the sequencer and response valid and restores the
// round count; key slots are undefined until loaded.
module aes_block_encrypt_variable_rounds_top #(
   parameter int MAX_ROUNDS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [3:0]                   req_key_index,
   input  logic [aesvr_pkg::HALF_W-1:0] req_data_hi,
   input  logic [aesvr_pkg::HALF_W-1:0] req_data_lo,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [aesvr_pkg::HALF_W-1:0] rsp_ciphertext_hi,
   output logic [aesvr_pkg::HALF_W-1:0] rsp_ciphertext_lo,
   input  logic                         csr_wr_en,
   input  logic [3:0]                   csr_wr_data
);
   import aesvr_pkg::*;

   localparam int KeyDepth = MAX_ROUNDS + 1;
   localparam int KeyAw    = $clog2(KeyDepth);
   localparam logic [ROUND_W-1:0] MaxRnd = ROUND_W'(MAX_ROUNDS);

   fsm_state_type      fsm_ff, fsm_in;
   logic [ROUND_W-1:0] rnd_ff, rnd_in;
   logic [ROUND_W-1:0] rcount_ff;
   logic [ROUND_W-1:0] rounds_eff;
   logic [WORD_W-1:0]  state_ff, state_in;
   logic [WORD_W-1:0]  lane_word;
   logic [WORD_W-1:0]  key_data;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_data_ff;
   logic               rsp_load;
   logic               req_accept;
   logic               key_wr;
   logic [ROUND_W-1:0] rnd_next;
   logic [KeyAw-1:0]   key_raddr;
   logic               last_round;
   logic               can_finish;
   logic [WORD_W-1:0]  plain_word;

   assign plain_word = {req_data_hi, req_data_lo};
   assign req_stall  = (fsm_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign key_wr     = req_accept && (req_command == CMD_LOAD) && (req_key_index <= MaxRnd);

   always_comb begin
      if (rcount_ff == '0) begin
         rounds_eff = ROUND_W'(1);
      end else if (rcount_ff > MaxRnd) begin
         rounds_eff = MaxRnd;
      end else begin
         rounds_eff = rcount_ff;
      end
   end

   // the last round keeps its own key while the response register is blocked
   always_comb begin
      rnd_next = (rnd_ff < MaxRnd) ? rnd_ff + ROUND_W'(1) : rnd_ff;
      if (fsm_ff == ST_IDLE) begin
         key_raddr = '0;
      end else if ((fsm_ff == ST_ROUND) && last_round) begin
         key_raddr = rnd_ff[KeyAw-1:0];
      end else begin
         key_raddr = rnd_next[KeyAw-1:0];
      end
   end

   aesvr_ram #(
      .WIDTH(WORD_W),
      .DEPTH(KeyDepth)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (key_wr),
      .wr_addr(req_key_index[KeyAw-1:0]),
      .wr_data(plain_word),
      .rd_addr(key_raddr),
      .rd_data(key_data)
   );

   assign last_round = (rnd_ff == rounds_eff);

   // shift rows is wiring: lane c row r takes old column (c + r) mod 4
   for (genvar c = 0; c < LANES; c++) begin : g_lane
      logic [COL_W-1:0] col_in;
      for (genvar r = 0; r < 4; r++) begin : g_row
         localparam int Src = r + 4 * ((c + r) % 4);
         assign col_in[COL_W-1-BYTE_W*r -: BYTE_W] = state_ff[WORD_W-1-BYTE_W*Src -: BYTE_W];
      end
      aesvr_lane u_lane (
         .col_in (col_in),
         .key_col(key_data[WORD_W-1-COL_W*c -: COL_W]),
         .mix_en (!last_round),
         .col_out(lane_word[WORD_W-1-COL_W*c -: COL_W])
      );
   end

   always_comb begin
      fsm_in       = fsm_ff;
      rnd_in       = rnd_ff;
      state_in     = state_ff;
      can_finish   = !rsp_valid_ff || !rsp_stall;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (fsm_ff)
         ST_IDLE: begin
            if (req_accept && (req_command == CMD_ENCRYPT)) begin
               state_in = plain_word;
               rnd_in   = '0;
               fsm_in   = ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = state_ff ^ key_data;
            rnd_in   = ROUND_W'(1);
            fsm_in   = ST_ROUND;
         end
         ST_ROUND: begin
            if (!last_round) begin
               state_in = lane_word;
               rnd_in   = rnd_next;
            end else if (can_finish) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               fsm_in       = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= ST_IDLE;
         rnd_ff       <= '0;
         rcount_ff    <= ROUND_W'(10);
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            rcount_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      if (rsp_load) begin
         rsp_data_ff <= lane_word;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ciphertext_hi = rsp_data_ff[WORD_W-1:HALF_W];
   assign rsp_ciphertext_lo = rsp_data_ff[HALF_W-1:0];

`ifndef SYNTH
   a_rsp_from_round: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fsm_ff == ST_ROUND))
      else $error("response raised outside the last round");

   a_rnd_bound: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_ROUND) |-> (rnd_ff >= ROUND_W'(1)) && (rnd_ff <= rounds_eff))
      else $error("round counter out of range");

   a_enc_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_command == CMD_ENCRYPT) |=> (fsm_ff == ST_INIT))
      else $error("encrypt did not start the key add");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_command == CMD_LOAD) |=>
         (fsm_ff == ST_IDLE) && (rsp_data_ff === $past(rsp_data_ff)))
      else $error("load disturbed the sequencer or response");
`endif

endmodule

// ===== tb/sv/aes_block_encrypt_variable_rounds_checker.sv =====
// checker for the variable-round cipher: tracks keys and round count, predicts and compares
module aes_block_encrypt_variable_rounds_checker #(
   parameter int MAX_ROUNDS = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         req_command,
   input  logic [3:0]                   req_key_index,
   input  logic [aesvr_pkg::HALF_W-1:0] req_data_hi,
   input  logic [aesvr_pkg::HALF_W-1:0] req_data_lo,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [aesvr_pkg::HALF_W-1:0] rsp_ciphertext_hi,
   input  logic [aesvr_pkg::HALF_W-1:0] rsp_ciphertext_lo,
   input  logic                         csr_wr_en,
   input  logic [3:0]                   csr_wr_data,
   output int                           outstanding,
   output int                           failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import aesvr_pkg::*;

   typedef struct packed {
      logic [HALF_W-1:0] hi;
      logic [HALF_W-1:0] lo;
   } cipher_word;

   localparam logic [7:0] SUB_TABLE [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
      8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
      8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
      8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
      8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
      8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
      8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
      8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
      8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
      8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
      8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
      8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
      8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
      8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
      8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
      8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
      8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   logic [2*HALF_W-1:0] round_keys [0:MAX_ROUNDS];
   logic [3:0]          round_cfg;
   cipher_word          cipher_q [$];

   function automatic logic [7:0] gf_double(input logic [7:0] x);
      return x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
   endfunction

   function automatic logic [2*HALF_W-1:0] encrypt_block(input logic [2*HALF_W-1:0] plain);
      logic [7:0]          st [16];
      logic [7:0]          t [16];
      logic [7:0]          a0, a1, a2, a3;
      logic [2*HALF_W-1:0] res;
      int                  nr;
      nr = (round_cfg == 0) ? 1 : ((round_cfg > MAX_ROUNDS) ? MAX_ROUNDS : int'(round_cfg));
      for (int n = 0; n < 16; n++)
         st[n] = plain[127-8*n -: 8] ^ round_keys[0][127-8*n -: 8];
      for (int r = 1; r <= nr; r++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               t[w + 4*((c + 4 - w) % 4)] = SUB_TABLE[st[w + 4*c]];
         st = t;
         if (r != nr) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[4*c];
               a1 = st[4*c+1];
               a2 = st[4*c+2];
               a3 = st[4*c+3];
               st[4*c]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
               st[4*c+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
               st[4*c+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
               st[4*c+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
            end
         end
         for (int n = 0; n < 16; n++)
            st[n] = st[n] ^ round_keys[r][127-8*n -: 8];
      end
      for (int n = 0; n < 16; n++)
         res[127-8*n -: 8] = st[n];
      return res;
   endfunction

   initial begin
      outstanding = 0;
      failures = 0;
      round_cfg = 4'd10;
   end

   always @(posedge clock) begin : watch
      cipher_word want;
      if (reset) begin
         round_cfg = 4'd10;
         cipher_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cipher_q.size() == 0) begin
               $error("unexpected response word: ciphertext_hi %h, ciphertext_lo %h",
                      rsp_ciphertext_hi, rsp_ciphertext_lo);
               failures++;
            end else begin
               want = cipher_q.pop_front();
               if (rsp_ciphertext_hi !== want.hi) begin
                  $error("ciphertext_hi mismatch: expected %h, actual %h",
                         want.hi, rsp_ciphertext_hi);
                  failures++;
               end
               if (rsp_ciphertext_lo !== want.lo) begin
                  $error("ciphertext_lo mismatch: expected %h, actual %h",
                         want.lo, rsp_ciphertext_lo);
                  failures++;
               end
            end
         end
         if (csr_wr_en)
            round_cfg = csr_wr_data;
         if (req_valid && !req_stall) begin
            if (cmd_type'(req_command) == CMD_ENCRYPT)
               cipher_q.push_back(encrypt_block({req_data_hi, req_data_lo}));
            else if (req_key_index <= MAX_ROUNDS)
               round_keys[req_key_index] = {req_data_hi, req_data_lo};
         end
      end
      outstanding = cipher_q.size();
   end

endmodule

// ===== tb/sv/aes_block_encrypt_variable_rounds_top_tb.sv =====
// testbench top for the variable-round cipher: clock, reset, stimulus and verdict
module aes_block_encrypt_variable_rounds_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import aesvr_pkg::*;

   localparam int MAX_ROUNDS    = 14;
   localparam int PHASES        = 8;
   localparam int PHASE_WORDS   = 165;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 400;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_command;
   logic [3:0]        req_key_index;
   logic [HALF_W-1:0] req_data_hi;
   logic [HALF_W-1:0] req_data_lo;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [HALF_W-1:0] rsp_ciphertext_hi;
   logic [HALF_W-1:0] rsp_ciphertext_lo;
   logic              csr_wr_en;
   logic [3:0]        csr_wr_data;
   logic              calm;
   logic              hold_phase;
   int                outstanding;
   int                failures;

   always #1 clock = ~clock;

   aes_block_encrypt_variable_rounds_top #(
      .MAX_ROUNDS(MAX_ROUNDS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_key_index    (req_key_index),
      .req_data_hi      (req_data_hi),
      .req_data_lo      (req_data_lo),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ciphertext_hi(rsp_ciphertext_hi),
      .rsp_ciphertext_lo(rsp_ciphertext_lo),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   aes_block_encrypt_variable_rounds_checker #(
      .MAX_ROUNDS(MAX_ROUNDS)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_key_index    (req_key_index),
      .req_data_hi      (req_data_hi),
      .req_data_lo      (req_data_lo),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ciphertext_hi(rsp_ciphertext_hi),
      .rsp_ciphertext_lo(rsp_ciphertext_lo),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .outstanding      (outstanding),
      .failures         (failures)
   );

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 93)
         return $urandom_range(1, 4);
      return $urandom_range(12, 50);
   endfunction

   function automatic logic [HALF_W-1:0] rand_half();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic send_word(input cmd_type cmd, input logic [3:0] idx,
                            input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo);
      int gap;
      gap = calm ? 0 : idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_key_index <= idx;
      req_data_hi   <= hi;
      req_data_lo   <= lo;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_rounds(input logic [3:0] n);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // response side: random stalls plus one long hold-off
   initial begin
      int open_left;
      int stall_left;
      bit held;
      open_left  = 0;
      stall_left = 0;
      held       = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_phase && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (open_left == 0 && stall_left == 0) begin
               open_left  = calm ? 64 : $urandom_range(1, 24);
               stall_left = calm ? 0 : idle_len();
            end
            if (open_left > 0) begin
               rsp_stall <= 1'b0;
               open_left--;
            end else begin
               rsp_stall <= 1'b1;
               stall_left--;
            end
         end
      end
   end

   initial begin
      logic [3:0] corner_rounds [4];
      logic [3:0] rounds_pick;
      corner_rounds = '{4'd1, 4'd14, 4'd0, 4'd15};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_command   = CMD_LOAD;
      req_key_index = '0;
      req_data_hi   = '0;
      req_data_lo   = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      calm          = 1'b0;
      hold_phase    = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // fill every key slot before the first encrypt
      send_word(CMD_LOAD, 4'd0, '0, '0);
      send_word(CMD_LOAD, 4'd1, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
      for (int k = 2; k < MAX_ROUNDS; k++)
         send_word(CMD_LOAD, 4'(k), rand_half(), rand_half());
      send_word(CMD_LOAD, 4'd14, '1, '1);
      // out-of-range slot, must be ignored
      send_word(CMD_LOAD, 4'd15, rand_half(), rand_half());
      send_word(CMD_ENCRYPT, 4'd0, '0, '0);
      send_word(CMD_ENCRYPT, 4'd15, '1, '1);
      send_word(CMD_ENCRYPT, 4'd5, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
      foreach (corner_rounds[i]) begin
         write_rounds(corner_rounds[i]);
         send_word(CMD_ENCRYPT, 4'($urandom_range(0, 15)), rand_half(), rand_half());
         send_word(CMD_ENCRYPT, 4'($urandom_range(0, 15)), rand_half(), rand_half());
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: rounds_pick = 4'd10;
            1: rounds_pick = 4'd14;
            2: rounds_pick = 4'd1;
            default: rounds_pick = 4'($urandom_range(0, 15));
         endcase
         write_rounds(rounds_pick);
         calm       <= (phase == 3);
         hold_phase <= (phase == 5);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 3) == 0)
               send_word(CMD_LOAD, 4'($urandom_range(0, 15)), rand_half(), rand_half());
            else
               send_word(CMD_ENCRYPT, 4'($urandom_range(0, 15)), rand_half(), rand_half());
         end
      end

      settle();
      if (failures == 0)
         $display("aes_block_encrypt_variable_rounds_top test passed");
      else
         $display("aes_block_encrypt_variable_rounds_top test failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("aes_block_encrypt_variable_rounds_top test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/aesvr_pkg.sv
sv/aesvr_ram.sv
sv/aesvr_lane.sv
sv/aes_block_encrypt_variable_rounds_top.sv
tb/sv/aes_block_encrypt_variable_rounds_checker.sv
tb/sv/aes_block_encrypt_variable_rounds_top_tb.sv
